// File: sv/ssti_pkg.sv
`default_nettype none
package ssti_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam int FracBits = 16;

  typedef enum logic [1:0] {
    OP_EVAL  = 2'd0,
    OP_INS   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_STEP    = 2'd0,
    MODE_NEAREST = 2'd1,
    MODE_LINEAR  = 2'd2,
    MODE_LINEAR2 = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_RD_LO,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_FIN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// File: sv/ssti_if.sv
`default_nettype none
interface ssti_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic signed [31:0] point_time;
  logic signed [31:0] point_value;
  modport source (output valid, op, point_time, point_value, input ready);
  modport sink (input valid, op, point_time, point_value, output ready);
endinterface

interface ssti_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        status;
  logic [6:0]  point_count;
  modport source (output valid, result_value, status, point_count, input ready);
  modport sink (input valid, result_value, status, point_count, output ready);
endinterface
`default_nettype wire

// File: sv/sorted_sample_table_interpolator_top.sv
// Keeps up to 64 time-sorted Q16.16 points and serves evaluate, insert and clear
// requests one at a time; ready is low while a request is in work. A clear or an
// undefined request goes straight to the output register. Evaluate binary-searches
// the point memory (a read and a compare state per probe, up to 7 probes), then for
// a linear interior query forms a 64-bit product and runs a 64-step restoring divide
// whose steps after the first share one subtract unit; step, nearest and clamped
// queries skip both. Insert searches the same way, then replaces an equal time's
// value, flags a full table, or moves later points up one place, a read and a write
// state per point. The memory has one read and one write port, read registered.
// A result waits in an output register; the next request is taken once it is taken.
`default_nettype none
module sorted_sample_table_interpolator_top (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  ssti_in_if.sink    in_ch,
  ssti_out_if.source out_ch
);
  localparam int IW = ssti_pkg::IdxW;
  localparam int CW = ssti_pkg::CntW;

  logic [63:0] mem [ssti_pkg::MaxPoints];
  logic [63:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [63:0]   wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  wire logic signed [31:0] rd_t = rd_data[63:32];
  wire logic signed [31:0] rd_v = rd_data[31:0];

  ssti_pkg::state_t state, state_next;
  ssti_pkg::mode_t mode;
  logic [1:0] op;
  logic signed [31:0] qt, qv;
  logic [CW-1:0] count, lo, hi, idx;
  logic signed [31:0] t1, v1, t0, v0;
  logic [63:0] prod, rem, quo;
  logic [31:0] span;
  logic        neg;
  logic [6:0]  step;
  logic signed [31:0] res;
  logic        status;
  logic        state_prev_div;

  logic [CW-1:0] mid;
  assign mid = lo + ((hi - lo) >> 1);

  always_ff @(posedge clk) begin
    if (rst) mode <= ssti_pkg::MODE_LINEAR;
    else if (cfg_we) mode <= ssti_pkg::mode_t'(cfg_wdata);
  end

  assign in_ch.ready = (state == ssti_pkg::S_IDLE);
  assign out_ch.valid = (state == ssti_pkg::S_OUT);
  assign out_ch.result_value = res;
  assign out_ch.status = status;
  assign out_ch.point_count = 7'(count);

  // Shared subtract unit for the restoring divide.
  logic [64:0] dsub;
  logic [63:0] rsh;
  assign rsh = {rem[62:0], quo[63]};
  assign dsub = {1'b0, rsh} - {33'd0, span};

  logic signed [33:0] dlo, dhi;
  assign dlo = 34'(qt) - 34'(t0);
  assign dhi = 34'(t1) - 34'(qt);
  logic signed [33:0] sum;
  assign sum = neg ? 34'(v0) - $signed({2'b00, quo[31:0]}) :
                     34'(v0) + $signed({2'b00, quo[31:0]});

  // Unsigned factors of the product: offset into the interval and size of the step.
  logic [31:0] mul_a, mul_b;
  assign mul_a = dlo[31:0];
  assign mul_b = (v1 < v0) ? 32'(34'(v0) - 34'(v1)) : 32'(34'(v1) - 34'(v0));

  always_comb begin
    state_next = state;
    rd_addr = mid[IW-1:0];
    wr_en = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_data = {qt, qv};
    case (state)
      ssti_pkg::S_IDLE: if (in_ch.valid) begin
        case (ssti_pkg::op_t'(in_ch.op))
          ssti_pkg::OP_EVAL, ssti_pkg::OP_INS: state_next = ssti_pkg::S_SRCH_RD;
          default: state_next = ssti_pkg::S_OUT;
        endcase
      end
      ssti_pkg::S_SRCH_RD:
        state_next = (lo < hi) ? ssti_pkg::S_SRCH_CMP : ssti_pkg::S_DECIDE;
      ssti_pkg::S_SRCH_CMP: state_next = ssti_pkg::S_SRCH_RD;
      ssti_pkg::S_DECIDE: begin
        rd_addr = lo[IW-1:0];
        if (op == ssti_pkg::OP_INS) state_next = ssti_pkg::S_RD_LO;
        else if (count == '0) state_next = ssti_pkg::S_FIN;
        else if (lo >= count) begin
          rd_addr = IW'(count - CW'(1));
          state_next = ssti_pkg::S_FIN;
        end else if (count == CW'(1)) state_next = ssti_pkg::S_FIN;
        else state_next = ssti_pkg::S_RD_LO;
      end
      ssti_pkg::S_RD_LO: begin
        rd_addr = IW'(lo - CW'(1));
        if (op == ssti_pkg::OP_INS) begin
          if (lo < count && rd_t == qt) begin
            wr_en = 1'b1;
            wr_addr = lo[IW-1:0];
            state_next = ssti_pkg::S_OUT;
          end else if (count >= CW'(ssti_pkg::MaxPoints)) state_next = ssti_pkg::S_OUT;
          else state_next = ssti_pkg::S_SHIFT_RD;
        end else if (lo == '0 || rd_t == qt) begin
          rd_addr = lo[IW-1:0];
          state_next = ssti_pkg::S_FIN;
        end else state_next = ssti_pkg::S_EVAL;
      end
      ssti_pkg::S_EVAL: begin
        if (mode == ssti_pkg::MODE_STEP || mode == ssti_pkg::MODE_NEAREST)
          state_next = ssti_pkg::S_OUT;
        else state_next = ssti_pkg::S_MUL;
      end
      ssti_pkg::S_MUL: state_next = ssti_pkg::S_DIV;
      ssti_pkg::S_DIV: if (step == 7'd63) state_next = ssti_pkg::S_FIN;
      ssti_pkg::S_FIN: state_next = ssti_pkg::S_OUT;
      ssti_pkg::S_SHIFT_RD: begin
        rd_addr = IW'(idx - CW'(1));
        if (idx == lo) begin
          wr_en = 1'b1;
          state_next = ssti_pkg::S_OUT;
        end else state_next = ssti_pkg::S_SHIFT_WR;
      end
      ssti_pkg::S_SHIFT_WR: begin
        wr_en = 1'b1;
        wr_data = rd_data;
        state_next = ssti_pkg::S_SHIFT_RD;
      end
      ssti_pkg::S_OUT: if (out_ch.ready) state_next = ssti_pkg::S_IDLE;
      default: state_next = ssti_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ssti_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        ssti_pkg::S_IDLE: if (in_ch.valid) begin
          op <= in_ch.op;
          qt <= in_ch.point_time;
          qv <= in_ch.point_value;
          lo <= '0;
          hi <= count;
          res <= '0;
          status <= 1'b0;
          if (ssti_pkg::op_t'(in_ch.op) == ssti_pkg::OP_CLEAR) count <= '0;
        end
        ssti_pkg::S_SRCH_CMP: begin
          if (rd_t < qt) lo <= mid + CW'(1);
          else hi <= mid;
        end
        ssti_pkg::S_DECIDE: begin
          idx <= count;
          if (op == ssti_pkg::OP_EVAL && count == '0)
            res <= 32'(1 << ssti_pkg::FracBits);
        end
        ssti_pkg::S_RD_LO: begin
          t1 <= rd_t;
          v1 <= rd_v;
          if (op == ssti_pkg::OP_INS && !(lo < count && rd_t == qt) &&
              count >= CW'(ssti_pkg::MaxPoints))
            status <= 1'b1;
        end
        ssti_pkg::S_EVAL: begin
          t0 <= rd_t;
          v0 <= rd_v;
          if (mode == ssti_pkg::MODE_STEP) res <= rd_v;
          else if (mode == ssti_pkg::MODE_NEAREST)
            res <= ((34'(qt) - 34'(rd_t)) <= (34'(t1) - 34'(qt))) ? rd_v : v1;
        end
        ssti_pkg::S_MUL: begin
          // Both factors fit in 32 bits unsigned: times are sorted, values 32-bit.
          span <= 32'(dhi + dlo);
          neg  <= v1 < v0;
          prod <= 64'(mul_a) * 64'(mul_b);
          step <= '0;
        end
        ssti_pkg::S_DIV: begin
          step <= step + 7'd1;
          if (step == 7'd0) begin
            // First bit uses the fresh product directly.
            if ({63'd0, prod[63]} >= {32'd0, span}) begin
              rem <= {63'd0, prod[63]} - {32'd0, span};
              quo <= {prod[62:0], 1'b1};
            end else begin
              rem <= {63'd0, prod[63]};
              quo <= {prod[62:0], 1'b0};
            end
          end else if (!dsub[64]) begin
            rem <= dsub[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rsh;
            quo <= {quo[62:0], 1'b0};
          end
        end
        ssti_pkg::S_FIN: begin
          if (count != '0 && (state_prev_div)) begin
            if (sum > 34'sh07FFFFFFF || quo[63:32] != '0 && !neg) res <= 32'h7FFFFFFF;
            else if (sum < -34'sh080000000 || quo[63:32] != '0 && neg)
              res <= 32'h80000000;
            else res <= 32'(sum);
          end else if (count != '0) res <= rd_v;
        end
        ssti_pkg::S_SHIFT_RD: if (idx == lo) count <= count + CW'(1);
        ssti_pkg::S_SHIFT_WR: idx <= idx - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state_prev_div <= 1'b0;
    else state_prev_div <= (state == ssti_pkg::S_DIV);
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ssti_pkg::MaxPoints))
    else $error("point count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid)
    else $error("request taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == ssti_pkg::S_SHIFT_WR) |=> (idx == $past(idx) - CW'(1)))
    else $error("shift index did not step");
  assert property (@(posedge clk) disable iff (rst)
    status |-> (op == ssti_pkg::OP_INS))
    else $error("status flagged for non-insert");
endmodule
`default_nettype wire

// File: test/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ssti_pkg::op_t op;
    logic signed [31:0] t;
    logic signed [31:0] v;
  } request_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic status;
    logic [6:0] count;
  } answer_t;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  ssti_in_if in_ch ();
  ssti_out_if out_ch ();

  sorted_sample_table_interpolator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Shadow of the point table.
  logic signed [31:0] tbl_times [ssti_pkg::MaxPoints];
  logic signed [31:0] tbl_values [ssti_pkg::MaxPoints];
  int unsigned tbl_count = 0;
  ssti_pkg::mode_t shadow_mode = ssti_pkg::MODE_LINEAR;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_off = 0;
  int stall_phase = 0;
  bit long_hold_done = 1'b0;
  bit enable_traffic = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic int unsigned upper_index(logic signed [31:0] t);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_times[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic signed [31:0] lerp(logic signed [31:0] t, int unsigned up);
    longint t0, t1, v0, v1, dv, r;
    logic [63:0] span, a, b, q;
    t0 = tbl_times[up - 1];
    t1 = tbl_times[up];
    v0 = tbl_values[up - 1];
    v1 = tbl_values[up];
    span = t1 - t0;
    a = longint'(t) - t0;
    dv = v1 - v0;
    b = dv < 0 ? -dv : dv;
    q = (a * b) / span;
    r = dv < 0 ? v0 - longint'(q) : v0 + longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] table_lookup(logic signed [31:0] t);
    int unsigned up;
    longint dlo, dhi;
    if (tbl_count == 0) return 32'sd1 <<< ssti_pkg::FracBits;
    if (tbl_count == 1) return tbl_values[0];
    up = upper_index(t);
    if (up >= tbl_count) return tbl_values[tbl_count - 1];
    if (up == 0 || tbl_times[up] == t) return tbl_values[up];
    if (shadow_mode == ssti_pkg::MODE_STEP) return tbl_values[up - 1];
    if (shadow_mode == ssti_pkg::MODE_NEAREST) begin
      dlo = longint'(t) - tbl_times[up - 1];
      dhi = longint'(tbl_times[up]) - t;
      return dlo <= dhi ? tbl_values[up - 1] : tbl_values[up];
    end
    return lerp(t, up);
  endfunction

  function automatic logic table_insert(logic signed [31:0] t, logic signed [31:0] v);
    int unsigned pos;
    pos = upper_index(t);
    if (pos < tbl_count && tbl_times[pos] == t) begin
      tbl_values[pos] = v;
      return 1'b0;
    end
    if (tbl_count >= ssti_pkg::MaxPoints) return 1'b1;
    for (int unsigned i = tbl_count; i > pos; i--) begin
      tbl_times[i] = tbl_times[i - 1];
      tbl_values[i] = tbl_values[i - 1];
    end
    tbl_times[pos] = t;
    tbl_values[pos] = v;
    tbl_count++;
    return 1'b0;
  endfunction

  function automatic answer_t apply_request(request_t rq);
    answer_t ans;
    ans = '0;
    case (rq.op)
      ssti_pkg::OP_EVAL: ans.value = table_lookup(rq.t);
      ssti_pkg::OP_INS: ans.status = table_insert(rq.t, rq.v);
      ssti_pkg::OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    ans.count = tbl_count[6:0];
    return ans;
  endfunction

  task automatic queue_request(ssti_pkg::op_t op, logic [31:0] t, logic [31:0] v);
    request_t rq;
    rq.op = op;
    rq.t = t;
    rq.v = v;
    pending_requests.push_back(rq);
  endtask

  task automatic drain_and_set_mode(ssti_pkg::mode_t m);
    wait (pending_requests.size() == 0 && expected_answers.size() == 0);
    repeat (200) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    shadow_mode = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 40) << ssti_pkg::FracBits;
      3: return $urandom_range(0, 3) - 2;
      default: return $urandom();
    endcase
  endfunction

  // One phase of random traffic: mostly queries, mixed with inserts and a few clears and undefined requests.
  task automatic random_phase(int items);
    int n, k;
    logic [31:0] base;
    n = 0;
    while (n < items) begin
      k = $urandom_range(0, 99);
      if (k < 3) begin
        queue_request(ssti_pkg::OP_CLEAR, $urandom(), $urandom());
        n++;
      end else if (k < 5) begin
        queue_request(ssti_pkg::OP_NONE, $urandom(), $urandom());
        n++;
      end else if (k < 35) begin
        base = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 60) : random_word();
        queue_request(ssti_pkg::OP_INS, base, random_word());
        n++;
      end else begin
        base = ($urandom_range(0, 2) == 0) ? random_word() : $urandom_range(0, 64);
        queue_request(ssti_pkg::OP_EVAL, base, $urandom());
        n++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = ssti_pkg::OP_EVAL;
    in_ch.point_time = '0;
    in_ch.point_value = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    enable_traffic = 1'b1;

    // Directed: empty table, one point, clamping, exact hits, replace, full table.
    queue_request(ssti_pkg::OP_EVAL, 32'h0, 32'h0);
    queue_request(ssti_pkg::OP_NONE, 32'h5, 32'h5);
    queue_request(ssti_pkg::OP_INS, 32'h00010000, 32'h7fffffff);
    queue_request(ssti_pkg::OP_EVAL, 32'h80000000, 32'h0);
    queue_request(ssti_pkg::OP_INS, 32'h80000000, 32'h80000000);
    queue_request(ssti_pkg::OP_INS, 32'h7fffffff, 32'h7fffffff);
    queue_request(ssti_pkg::OP_EVAL, 32'h80000000, 32'hffffffff);
    queue_request(ssti_pkg::OP_EVAL, 32'h7fffffff, 32'h0);
    queue_request(ssti_pkg::OP_EVAL, 32'h00000000, 32'h0);
    queue_request(ssti_pkg::OP_EVAL, 32'h00010000, 32'h0);
    queue_request(ssti_pkg::OP_EVAL, 32'h40000000, 32'h0);
    queue_request(ssti_pkg::OP_INS, 32'h00010000, 32'h12345678);
    queue_request(ssti_pkg::OP_EVAL, 32'h00008000, 32'h0);
    queue_request(ssti_pkg::OP_CLEAR, 32'h0, 32'h0);
    queue_request(ssti_pkg::OP_EVAL, 32'h0, 32'h0);
    queue_request(ssti_pkg::OP_INS, 32'h00020000, 32'h00030000);
    queue_request(ssti_pkg::OP_INS, 32'h00040000, 32'h00010000);
    queue_request(ssti_pkg::OP_EVAL, 32'h00030000, 32'h0);
    queue_request(ssti_pkg::OP_EVAL, 32'h00050000, 32'h0);
    for (int i = 0; i < ssti_pkg::MaxPoints + 1; i++)
      queue_request(ssti_pkg::OP_INS, i * 3, $urandom());
    queue_request(ssti_pkg::OP_INS, 32'h00000006, 32'hdeadbeef);
    queue_request(ssti_pkg::OP_EVAL, 32'h00000004, 32'h0);
    drain_and_set_mode(ssti_pkg::MODE_STEP);
    queue_request(ssti_pkg::OP_EVAL, 32'h00000004, 32'h0);
    drain_and_set_mode(ssti_pkg::MODE_NEAREST);
    queue_request(ssti_pkg::OP_EVAL, 32'h00000004, 32'h0);
    queue_request(ssti_pkg::OP_EVAL, 32'h00000005, 32'h0);
    queue_request(ssti_pkg::OP_CLEAR, 32'h0, 32'h0);
    queue_request(ssti_pkg::OP_INS, 32'h0, 32'h0);
    queue_request(ssti_pkg::OP_INS, 32'h2, 32'h64);
    queue_request(ssti_pkg::OP_EVAL, 32'h1, 32'h0);

    drain_and_set_mode(ssti_pkg::MODE_NEAREST);
    random_phase(320);
    drain_and_set_mode(ssti_pkg::MODE_STEP);
    random_phase(320);
    drain_and_set_mode(ssti_pkg::MODE_LINEAR2);
    random_phase(320);
    drain_and_set_mode(ssti_pkg::MODE_LINEAR);
    random_phase(370);
    wait (pending_requests.size() == 0 && expected_answers.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (enable_traffic) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_answers.push_back(apply_request(pending_requests.pop_front()));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() > 0 && !(cfg_we)) begin
          in_ch.valid <= 1'b1;
          in_ch.op <= pending_requests[0].op;
          in_ch.point_time <= pending_requests[0].t;
          in_ch.point_value <= pending_requests[0].v;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls on its own rhythm, with one long hold-off while requests wait.
  always @(posedge clk) begin
    if (enable_traffic) begin
      stall_phase <= stall_phase + 1;
      if (!long_hold_done && stall_phase >= 2000 && pending_requests.size() > 8) begin
        long_hold_done <= 1'b1;
        hold_off <= 1500;
        out_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_phase % 4000 < 1000) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    answer_t got, want;
    if (enable_traffic) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (hold_off == 0) begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > WatchdogLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.value = out_ch.result_value;
        got.status = out_ch.status;
        got.count = out_ch.point_count;
        if (expected_answers.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected transfer: value %h status %b count %0d",
                                        got.value, got.status, got.count);
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: value %h/%h status %b/%b count %0d/%0d (exp/got)",
                       want.value, got.value, want.status, got.status,
                       want.count, got.count);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire
